// File: hdl/rtg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtg_pkg
// Shared types and constants for the ramped tone generator: request and
// result words, field widths, register indexes and sample limits.
// ----------------------------------------------------------------------------
package rtg_pkg;

  localparam int OSC_W          = 32;
  localparam int TOT_W          = 24;
  localparam int VOL_W          = 15;
  localparam int SMP_W          = 16;
  localparam int FRAC_BITS      = 30;
  localparam int COUNT_BITS_DEF = 24;
  localparam int CNT_W          = $clog2(OSC_W);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OSC_COEF      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_OLDER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_NEWER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_SAMPLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_MODE      = 3'd6;

  localparam logic [SMP_W-1:0] SMP_MAX = 16'h7fff;
  localparam logic [SMP_W-1:0] SMP_MIN = 16'h8000;
  localparam logic [OSC_W-1:0] OSC_MAX = 32'h7fff_ffff;
  localparam logic [OSC_W-1:0] OSC_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                    start_req;
    logic signed [SMP_W-1:0] existing_sample;
  } rtg_req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    valid_res;
    logic                    is_last;
    logic                    overflow;
  } rtg_res_t;

endpackage
`default_nettype wire

// File: hdl/ramped_tone_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ramped_tone_generator_core
// Recursive sine oscillator with linear fade in/out, one sample per request.
//
// Usage: load the registers through cfg_we/cfg_index/cfg_data while idle.
// Each request on req (valid/ready) yields exactly one result on res.
// A request with start_req set reloads the seeds and restarts the burst.
// Requests beyond the burst return a zero result with valid_res low.
// A request inside the burst passes the prepare, oscillator multiply, update,
// tone multiply and final steps to the registered result; one beyond it goes
// from prepare straight to final. A new request is taken only back in idle;
// the 32-step bit-serial oscillator multiply and the 15-step serial tone
// multiply share one shift-add unit, with the ramp divide beside the first.
// Reset clears the configuration registers, the oscillator state, the sample index and res_valid.
// When the receiver stalls, the result register holds; the next request is
// still accepted and computed, and its result waits in the final step
// until the register is taken.
// ----------------------------------------------------------------------------
module ramped_tone_generator_core #(
  parameter int COUNT_BITS = rtg_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  rtg_pkg::rtg_req_t                req,
  output logic                             res_valid,
  input  logic                             res_ready,
  output rtg_pkg::rtg_res_t                res,
  input  logic                             cfg_we,
  input  logic [rtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int OW    = rtg_pkg::OSC_W;
  localparam int TW    = rtg_pkg::TOT_W;
  localparam int VW    = rtg_pkg::VOL_W;
  localparam int SW    = rtg_pkg::SMP_W;
  localparam int FB    = rtg_pkg::FRAC_BITS;
  localparam int CW    = rtg_pkg::CNT_W;
  localparam int TP    = OW + VW;
  localparam int CMP_W = (COUNT_BITS > TW) ? COUNT_BITS : TW;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_OSC, S_NV, S_TONE, S_FIN} state_t;

  // configuration
  logic [OW-1:0]         osc_coef;
  logic [OW-1:0]         seed_older;
  logic [OW-1:0]         seed_newer;
  logic [TW-1:0]         total_samples;
  logic [TW-1:0]         ramp_samples;
  logic [VW-1:0]         volume;
  logic                  add_mode;

  // oscillator and burst state
  logic [OW-1:0]         osc_older;
  logic [OW-1:0]         osc_newer;
  logic [COUNT_BITS-1:0] sample_index;

  state_t                state;
  logic [CW-1:0]         cnt;

  // shared shift-add multiplier
  logic [OW-1:0]         mplr;
  logic [OW:0]           acc_hi;
  logic [OW-1:0]         acc_lo;

  // ramp multiply / divide
  logic [TW-1:0]         amp_mcand;
  logic [VW-1:0]         amp_mplr;
  logic [TW-1:0]         div_rem;
  logic [VW-1:0]         div_lo;

  logic                  beyond;
  logic                  last_q;
  logic                  ramp_act;
  logic [SW-1:0]         ex_q;

  // burst position decode
  logic [CMP_W-1:0]      idx_ext;
  logic [CMP_W-1:0]      tot_ext;
  logic [CMP_W-1:0]      rmp_ext;
  logic [CMP_W-1:0]      tot_minus;
  logic                  beyond_c;
  logic                  in_up;
  logic                  in_dn;
  logic                  last_c;
  logic                  ramp_c;
  logic [TW-1:0]         amp_m;

  always_comb begin
    idx_ext   = CMP_W'(sample_index);
    tot_ext   = CMP_W'(total_samples);
    rmp_ext   = CMP_W'(ramp_samples);
    tot_minus = tot_ext - idx_ext;
    beyond_c  = idx_ext >= tot_ext;
    in_up     = idx_ext < rmp_ext;
    in_dn     = ({1'b0, idx_ext} + {1'b0, rmp_ext}) > {1'b0, tot_ext};
    last_c    = ({1'b0, idx_ext} + (CMP_W+1)'(1)) == {1'b0, tot_ext};
    ramp_c    = (ramp_samples != '0) && (in_up || in_dn);
    amp_m     = in_up ? idx_ext[TW-1:0] : tot_minus[TW-1:0];
  end

  // multiplier step; the sign bit of the oscillator multiplier subtracts
  logic [OW-1:0]   mcand;
  logic [OW+1:0]   mc_ext;
  logic [OW+1:0]   addend;
  logic [OW+1:0]   msum;
  logic            neg_step;

  always_comb begin
    mcand    = (state == S_OSC) ? osc_coef : osc_newer;
    mc_ext   = {{2{mcand[OW-1]}}, mcand};
    neg_step = (state == S_OSC) && (cnt == CW'(OW-1));
    if (!mplr[0]) begin
      addend = '0;
    end else if (neg_step) begin
      addend = '0 - mc_ext;
    end else begin
      addend = mc_ext;
    end
    msum = {acc_hi[OW], acc_hi} + addend;
  end

  // ramp multiply and restoring divide steps
  logic [TW:0] asum;
  logic [TW:0] dt;
  logic [TW:0] ddiff;
  logic        dge;

  always_comb begin
    asum  = {1'b0, div_rem} + (amp_mplr[0] ? {1'b0, amp_mcand} : '0);
    dt    = {div_rem, div_lo[VW-1]};
    dge   = dt >= {1'b0, ramp_samples};
    ddiff = dt - {1'b0, ramp_samples};
  end

  // oscillator update: floor shift, subtract, saturate
  logic signed [2*OW-1:0] prod_o;
  logic signed [2*OW-1:0] fl;
  logic [2*OW:0]          diff;
  logic [OW-1:0]          nv_c;
  logic [VW-1:0]          amp_c;

  always_comb begin
    prod_o = $signed({acc_hi[OW-1:0], acc_lo});
    fl     = prod_o >>> FB;
    diff   = {fl[2*OW-1], fl} - {{(OW+1){osc_older[OW-1]}}, osc_older};
    if ((diff[2*OW:OW-1] == '0) || (diff[2*OW:OW-1] == '1)) begin
      nv_c = diff[OW-1:0];
    end else begin
      nv_c = diff[2*OW] ? rtg_pkg::OSC_MIN : rtg_pkg::OSC_MAX;
    end
    amp_c = ramp_act ? div_lo : volume;
  end

  // tone: truncate toward zero, saturate, optional add
  logic signed [TP-1:0] tprod;
  logic signed [TP-1:0] tsum;
  logic signed [TP-1:0] tsh;
  logic [SW-1:0]        tone;
  logic [SW:0]          sum17;
  logic [SW-1:0]        smp_c;
  logic                 ovf_c;

  always_comb begin
    tprod = $signed({acc_hi[OW-1:0], acc_lo[OW-1:OW-VW]});
    tsum  = tprod + (tprod[TP-1] ? $signed({{(TP-FB){1'b0}}, {FB{1'b1}}}) : '0);
    tsh   = tsum >>> FB;
    if ((tsh[TP-1:SW-1] == '0) || (tsh[TP-1:SW-1] == '1)) begin
      tone = tsh[SW-1:0];
    end else begin
      tone = tsh[TP-1] ? rtg_pkg::SMP_MIN : rtg_pkg::SMP_MAX;
    end
    sum17 = {tone[SW-1], tone} + {ex_q[SW-1], ex_q};
    smp_c = add_mode ? sum17[SW-1:0] : tone;
    ovf_c = add_mode && (sum17[SW] ^ sum17[SW-1]);
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      res_valid     <= 1'b0;
      osc_coef      <= '0;
      seed_older    <= '0;
      seed_newer    <= '0;
      total_samples <= '0;
      ramp_samples  <= '0;
      volume        <= '0;
      add_mode      <= 1'b0;
      osc_older     <= '0;
      osc_newer     <= '0;
      sample_index  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rtg_pkg::REG_OSC_COEF:      osc_coef      <= cfg_data[OW-1:0];
          rtg_pkg::REG_SEED_OLDER:    seed_older    <= cfg_data[OW-1:0];
          rtg_pkg::REG_SEED_NEWER:    seed_newer    <= cfg_data[OW-1:0];
          rtg_pkg::REG_TOTAL_SAMPLES: total_samples <= cfg_data[TW-1:0];
          rtg_pkg::REG_RAMP_SAMPLES:  ramp_samples  <= cfg_data[TW-1:0];
          rtg_pkg::REG_VOLUME:        volume        <= cfg_data[VW-1:0];
          rtg_pkg::REG_ADD_MODE:      add_mode      <= cfg_data[0];
          default: ;
        endcase
      end

      // the final step handles the result register itself
      if (res_valid && res_ready && (state != S_FIN)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.start_req) begin
              osc_older    <= seed_older;
              osc_newer    <= seed_newer;
              sample_index <= '0;
            end
            ex_q  <= req.existing_sample;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          beyond    <= beyond_c;
          last_q    <= last_c;
          ramp_act  <= ramp_c;
          mplr      <= osc_newer;
          acc_hi    <= '0;
          amp_mcand <= amp_m;
          amp_mplr  <= volume;
          div_rem   <= '0;
          cnt       <= '0;
          state     <= beyond_c ? S_FIN : S_OSC;
        end
        S_OSC: begin
          acc_hi <= msum[OW+1:1];
          acc_lo <= {msum[0], acc_lo[OW-1:1]};
          mplr   <= mplr >> 1;
          if (cnt < CW'(VW)) begin
            div_rem  <= asum[TW:1];
            div_lo   <= {asum[0], div_lo[VW-1:1]};
            amp_mplr <= amp_mplr >> 1;
          end else if (cnt < CW'(2*VW)) begin
            div_rem <= dge ? ddiff[TW-1:0] : dt[TW-1:0];
            div_lo  <= {div_lo[VW-2:0], dge};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(OW-1)) begin
            state <= S_NV;
          end
        end
        S_NV: begin
          osc_older    <= osc_newer;
          osc_newer    <= nv_c;
          sample_index <= sample_index + 1'b1;
          mplr         <= OW'(amp_c);
          acc_hi       <= '0;
          cnt          <= '0;
          state        <= S_TONE;
        end
        S_TONE: begin
          acc_hi <= msum[OW+1:1];
          acc_lo <= {msum[0], acc_lo[OW-1:1]};
          mplr   <= mplr >> 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CW'(VW-1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            if (beyond) begin
              res.sample_out <= '0;
              res.valid_res  <= 1'b0;
              res.is_last    <= 1'b0;
              res.overflow   <= 1'b0;
            end else begin
              res.sample_out <= smp_c;
              res.valid_res  <= 1'b1;
              res.is_last    <= last_q;
              res.overflow   <= ovf_c;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // fade quotient never exceeds the peak volume
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NV && ramp_act) |-> (div_lo <= volume))
    else $error("ramp quotient above volume");

  a_osc_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_OSC && cnt == CW'(OW-1)) |=> (state == S_NV))
    else $error("oscillator multiply step count wrong");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside final step");

  a_beyond_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.valid_res) |->
      (res.sample_out == '0 && !res.is_last && !res.overflow))
    else $error("result beyond burst not cleared");

endmodule
`default_nettype wire
